[rtl/ptst_pkg.sv]
`timescale 1ns / 1ps
package ptst_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_POLL   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		KIND_ADDED   = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_REMOVED = 3'd2,
		KIND_FIRED   = 3'd3,
		KIND_IDLE    = 3'd4
	} kind_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_DIV,
		ST_FIRE,
		ST_FIN
	} state_e;

	typedef struct packed {
		logic [15:0] owner;
		logic [31:0] period;
		logic [31:0] start;
		logic        catch_up;
	} slot_t;

	typedef struct packed {
		logic latch;
		logic inc_idx;
		logic ev;
		logic div_start;
		logic load_pend;
		logic push_pend;
		logic push_fin;
	} ctl_t;

	typedef struct packed {
		logic req_valid;
		logic req_skip;
		logic last_idx;
		logic fire_ok;
		logic use_div;
		logic div_busy;
		logic pend_v;
		logic out_free;
	} sts_t;

endpackage

[rtl/ptst_req_if.sv]
`timescale 1ns / 1ps
interface ptst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] handle;
	logic [31:0] period_ms;
	logic        catch_up;
	logic [31:0] now_ms;

	modport source (output valid, command, handle, period_ms, catch_up, now_ms, input ready);
	modport sink (input valid, command, handle, period_ms, catch_up, now_ms, output ready);
endinterface

[rtl/ptst_rsp_if.sv]
`timescale 1ns / 1ps
interface ptst_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] handle_out;
	logic [31:0] fire_count;
	logic        last;

	modport source (output valid, kind, handle_out, fire_count, last, input ready);
	modport sink (input valid, kind, handle_out, fire_count, last, output ready);
endinterface

[rtl/ptst_ram.sv]
`timescale 1ns / 1ps
module ptst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/ptst_div.sv]
`timescale 1ns / 1ps
module ptst_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign rem_sh = {rem_q, quo_q[31]};
	assign diff = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
endmodule

[rtl/ptst_ctrl.sv]
`timescale 1ns / 1ps
module ptst_ctrl import ptst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl,
	output logic req_ready
);
	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.req_valid && !sts.req_skip) state_d = ST_RD;
			end
			ST_RD: state_d = ST_EV;
			ST_EV: begin
				if (sts.fire_ok) state_d = sts.use_div ? ST_DIV : ST_FIRE;
				else state_d = sts.last_idx ? ST_FIN : ST_RD;
			end
			ST_DIV: begin
				if (!sts.div_busy) state_d = ST_FIRE;
			end
			ST_FIRE: begin
				if (!sts.pend_v || sts.out_free) state_d = sts.last_idx ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				ctl.latch = sts.req_valid;
			end
			ST_EV: begin
				ctl.ev = 1'b1;
				ctl.div_start = sts.fire_ok && sts.use_div;
				ctl.inc_idx = !sts.fire_ok && !sts.last_idx;
			end
			ST_FIRE: begin
				if (!sts.pend_v || sts.out_free) begin
					ctl.load_pend = 1'b1;
					ctl.push_pend = sts.pend_v;
					ctl.inc_idx = !sts.last_idx;
				end
			end
			ST_FIN: ctl.push_fin = sts.out_free;
			default: ;
		endcase
	end
endmodule

[rtl/ptst_dp.sv]
`timescale 1ns / 1ps
module ptst_dp import ptst_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  ctl_t  ctl,
	output sts_t  sts,
	ptst_req_if.sink   req,
	ptst_rsp_if.source rsp
);
	localparam int IW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

	cmd_e            cmd_q;
	logic [15:0]     h_q;
	logic [31:0]     per_q;
	logic            cu_q;
	logic [31:0]     now_q;
	logic [IW-1:0]   idx_q;
	logic [SLOT_COUNT-1:0] occ_q;
	logic            found_q;
	logic [IW-1:0]   first_q;
	logic [RES_W-1:0] n_q;
	logic [15:0]     own_q;
	logic            use_div_q;
	logic            pend_v_q;
	logic [15:0]     pend_h_q;
	logic [31:0]     pend_c_q;
	logic            out_v_q;
	logic [2:0]      kind_q;
	logic [15:0]     hout_q;
	logic [31:0]     cnt_q;
	logic            last_q;

	slot_t           rd;
	slot_t           wd;
	logic            we;
	logic [IW-1:0]   waddr;
	logic            occ_i;
	logic            match;
	logic [31:0]     elapsed;
	logic            fire_ok;
	logic            use_div;
	logic            out_free;
	logic            div_busy;
	logic [31:0]     quot;
	logic            add_wr;

	ptst_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOT_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wd),
		.raddr (idx_q),
		.rdata (rd)
	);

	ptst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (elapsed),
		.divisor  (rd.period),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign occ_i = occ_q[idx_q];
	assign match = occ_i && (rd.owner == h_q);
	assign elapsed = now_q - rd.start;
	assign fire_ok = (cmd_q == CMD_POLL) && occ_i && (elapsed >= rd.period)
		&& (n_q < RES_W'(MAX_RESULTS));
	assign use_div = rd.catch_up && (rd.period != 32'd0);
	assign out_free = !out_v_q || rsp.ready;
	assign add_wr = ctl.push_fin && (cmd_q == CMD_ADD) && found_q;

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wd = '{owner: rd.owner, period: rd.period, start: now_q, catch_up: rd.catch_up};
		if (ctl.ev && fire_ok) begin
			we = 1'b1;
		end else if (add_wr) begin
			we = 1'b1;
			waddr = first_q;
			wd = '{owner: h_q, period: per_q, start: now_q, catch_up: cu_q};
		end
	end

	assign sts.req_valid = req.valid;
	assign sts.req_skip = (cmd_e'(req.command) == CMD_NONE)
		|| ((cmd_e'(req.command) != CMD_POLL) && (req.handle == 16'd0));
	assign sts.last_idx = idx_q == IW'(SLOT_COUNT - 1);
	assign sts.fire_ok = fire_ok;
	assign sts.use_div = use_div;
	assign sts.div_busy = div_busy;
	assign sts.pend_v = pend_v_q;
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd_e'(req.command);
			h_q <= req.handle;
			per_q <= req.period_ms;
			cu_q <= req.catch_up;
			now_q <= req.now_ms;
		end
		if (ctl.ev && !found_q && (!occ_i || match)) begin
			first_q <= idx_q;
		end
		if (ctl.ev && fire_ok) begin
			own_q <= rd.owner;
			use_div_q <= use_div;
		end
		if (ctl.load_pend) begin
			pend_h_q <= own_q;
			pend_c_q <= use_div_q ? quot : 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			occ_q <= '0;
			found_q <= 1'b0;
			n_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (ctl.latch) begin
				idx_q <= '0;
				found_q <= 1'b0;
				n_q <= '0;
				pend_v_q <= 1'b0;
			end else if (ctl.inc_idx) begin
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.ev) begin
				// drop any slot already owned by this handle
				if (match && (cmd_q != CMD_POLL)) occ_q[idx_q] <= 1'b0;
				if ((cmd_q == CMD_ADD) && (!occ_i || match)) found_q <= 1'b1;
				if (fire_ok) n_q <= n_q + RES_W'(1);
			end
			if (add_wr) occ_q[first_q] <= 1'b1;
			if (ctl.load_pend) pend_v_q <= 1'b1;
			else if (ctl.push_fin) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctl.push_pend || ctl.push_fin) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_pend) begin
			kind_q <= KIND_FIRED;
			hout_q <= pend_h_q;
			cnt_q <= pend_c_q;
			last_q <= 1'b0;
		end else if (ctl.push_fin) begin
			last_q <= 1'b1;
			hout_q <= h_q;
			cnt_q <= 32'd0;
			case (cmd_q)
				CMD_ADD: kind_q <= found_q ? KIND_ADDED : KIND_FULL;
				CMD_REMOVE: kind_q <= KIND_REMOVED;
				default: begin
					if (pend_v_q) begin
						kind_q <= KIND_FIRED;
						hout_q <= pend_h_q;
						cnt_q <= pend_c_q;
					end else begin
						kind_q <= KIND_IDLE;
						hout_q <= 16'd0;
					end
				end
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.kind = kind_q;
	assign rsp.handle_out = hout_q;
	assign rsp.fire_count = cnt_q;
	assign rsp.last = last_q;
endmodule

[rtl/periodic_timer_slot_table_unit.sv]
`timescale 1ns / 1ps
// Periodic timer slot table.
// req carries one command item: add, remove or poll, with a handle, a period,
// a catch-up flag and the current millisecond time. rsp returns result items;
// the final item of each command has last set.
// Add and remove answer with one item. Poll answers with one item per slot
// that fired (at most 16), or one nothing-fired item. Add or remove with a
// zero handle, and the unused command code, answer nothing.
// Every command walks the slot RAM one entry at a time, each entry through a
// read state and an evaluate state; each firing adds a fire state, and each
// catch-up firing also runs the bit-serial 32-bit divider. One command is
// worked on at a time; req.ready is high only between commands.
// Results leave through one output register. When rsp stalls, the walk holds
// until the register is free; the next command may be accepted while the
// final result still waits.
// Reset empties every slot at once (per-slot occupied flags) and clears all
// control state; no clearing pass is needed.
module periodic_timer_slot_table_unit import ptst_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ptst_req_if.sink   req,
	ptst_rsp_if.source rsp
);
	ctl_t ctl;
	sts_t sts;

	ptst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.ctl       (ctl),
		.req_ready (req.ready)
	);

	ptst_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);
endmodule
